@@ rtl/dc_motor_encoder_axis_assert.svh @@
// Assertion macros for the motor axis block.
// Included by the top level; compiles to nothing under SYNTHESIS.
`ifndef DC_MOTOR_ENCODER_AXIS_ASSERT_SVH
`define DC_MOTOR_ENCODER_AXIS_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication under reset.
`define AXIS_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("motor axis assertion failed");

// Next-cycle implication under reset.
`define AXIS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("motor axis assertion failed");

`else

`define AXIS_ASSERT_NOW(label, clk, rst_n, cond, expr)
`define AXIS_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

@@ rtl/dcme_pkg.sv @@
// Shared types and constants of the motor axis block.
// No dependencies; used by the divider and the top level.
package dcme_pkg;

    // PWM resolution; duty saturates to its top code
    localparam int          PWM_BITS = 8;
    localparam logic [16:0] PWM_TOP  = 17'((1 << PWM_BITS) - 1);

    // Field widths
    localparam int CMD_W  = 24;
    localparam int DIV_W  = 54;                  // widest dividend: |dz| * 6e6
    localparam int DEN_W  = 48;                  // widest divisor: ppr * dt
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int MUL_W  = 54;
    localparam int SCL_W  = 24;                  // rpm * |duty span|

    // Divider step counts
    localparam logic [CNT_W-1:0] SCL_STEPS  = CNT_W'(SCL_W);
    localparam logic [CNT_W-1:0] READ_STEPS = CNT_W'(DIV_W);

    // Arithmetic constants
    localparam logic [DEN_W-1:0] CENTI_DIV   = DEN_W'(100);
    // 2^30 / 100 rounded up: the product shifted down by 30 is exact whole rpm
    // for every 24-bit command magnitude
    localparam logic [31:0]      CENTI_RECIP = 32'd10737419;
    localparam int               CENTI_SHIFT = 30;
    localparam logic [31:0]      CRPM_SCALE  = 32'd6000000;  // 60 s * 1000 ms * 100
    localparam logic [DIV_W-1:0] SPD_POS_MAX = DIV_W'(64'h7FFF_FFFF);
    localparam logic [DIV_W-1:0] SPD_NEG_MAX = DIV_W'(64'h8000_0000);

    // Opcodes
    localparam logic [1:0] OP_EDGE  = 2'd0;
    localparam logic [1:0] OP_SPEED = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Register indexes
    localparam logic [2:0] CFG_MAX_RPM = 3'd0;
    localparam logic [2:0] CFG_MIN_PWM = 3'd1;
    localparam logic [2:0] CFG_MAX_PWM = 3'd2;
    localparam logic [2:0] CFG_PPR     = 3'd3;
    localparam logic [2:0] CFG_UM      = 3'd4;
    localparam logic [2:0] CFG_WINDOW  = 3'd5;

    // Direction codes
    localparam logic [1:0] DIR_OFF = 2'b00;
    localparam logic [1:0] DIR_FWD = 2'b01;
    localparam logic [1:0] DIR_REV = 2'b10;

    // Sequencer states
    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_SPD_RPM = 10'b00_0000_0010,
        S_SPD_MUL = 10'b00_0000_0100,
        S_SPD_GO  = 10'b00_0000_1000,
        S_SPD_DIV = 10'b00_0001_0000,
        S_RD_M1   = 10'b00_0010_0000,
        S_RD_M2   = 10'b00_0100_0000,
        S_RD_GO   = 10'b00_1000_0000,
        S_RD_DIV  = 10'b01_0000_0000,
        S_POST    = 10'b10_0000_0000
    } t_state;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;   // left aligned: quotient needs count steps
        logic [DEN_W-1:0] divisor;
        logic [CNT_W-1:0] count;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/dcme_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on dcme_pkg for widths and the request/response structs.
module dcme_divider
    import dcme_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] trial;
    logic             fits;

    // Shift in the next dividend bit and try a subtract
    assign rem_sh = {r_rem, r_quo[DIV_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, r_den};
    assign fits   = ~trial[DEN_W+1];

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], fits};
            r_rem <= fits ? trial[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ rtl/dc_motor_encoder_axis.sv @@
// Motor axis: encoder tick counter, PWM drive map and timed speed/position read.
// One item at a time: the next item can be taken in the same cycle that the result goes valid,
// later while the previous result is stalled; the shared divider (24 or 54 steps) dominates.
// Synchronous active-low reset restores the register defaults, clears all counts.
// Depends on dcme_pkg, dcme_divider and dc_motor_encoder_axis_assert.svh.
`include "dc_motor_encoder_axis_assert.svh"

module dc_motor_encoder_axis
    import dcme_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic               i_enc_a,
    input  logic               i_enc_b,
    input  logic signed [23:0] i_speed_cmd,
    input  logic [31:0]        i_now_ms,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_pwm_duty,
    output logic               o_drive_fwd,
    output logic               o_drive_rev,
    output logic signed [31:0] o_speed_centirpm,
    output logic signed [47:0] o_position_um,
    // register writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    // Registers
    logic [15:0] r_max_rpm, r_ppr, r_um, r_window;
    logic [7:0]  r_min_pwm, r_max_pwm;

    // Axis state
    t_state      r_state;
    logic [31:0] r_tick, r_last_tick, r_last_ms, r_speed;
    logic [47:0] r_pos;
    logic [7:0]  r_duty;
    logic [1:0]  r_dir;

    // Working registers
    logic             r_cmd_neg;
    logic [15:0]      r_rpm;
    logic             r_dz_neg;
    logic [31:0]      r_dz_mag;
    logic [31:0]      r_dt;
    logic [31:0]      r_now;
    logic [MUL_W-1:0] r_prod;
    logic [DIV_W-1:0] r_dividend;
    logic             r_out_valid;

    logic             in_accept;
    logic             cfg_we;
    logic [CMD_W-1:0] cmd_mag;
    logic [8:0]       span;
    logic             span_neg;
    logic [7:0]       span_mag;
    logic [31:0]      dt_now;
    logic [31:0]      dz;
    logic [15:0]      ppr_eff;
    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_full;
    logic             mul_en;
    logic [DIV_W-1:0] sat_q;
    logic [9:0]       duty_sum;
    logic             out_free;
    logic             div_wait;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    // Clamp a duty sum to the PWM range
    function automatic logic [7:0] sat_duty(input logic [9:0] d);
        logic [7:0] res;
        if (d[9]) begin
            res = '0;
        end else if ({7'b0, d} > PWM_TOP) begin
            res = PWM_TOP[7:0];
        end else begin
            res = d[7:0];
        end
        return res;
    endfunction

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign div_wait    = (r_state == S_SPD_DIV) || (r_state == S_RD_DIV);

    // Operand prep
    assign cmd_mag  = i_speed_cmd[23] ? CMD_W'(-i_speed_cmd) : CMD_W'(i_speed_cmd);
    assign span     = {1'b0, r_max_pwm} - {1'b0, r_min_pwm};
    assign span_neg = span[8];
    assign span_mag = span_neg ? 8'(-span) : span[7:0];
    assign dt_now   = i_now_ms - r_last_ms;
    assign dz       = r_tick - r_last_tick;
    assign ppr_eff  = (r_ppr == 16'd0) ? 16'd1 : r_ppr;
    assign duty_sum = span_neg ? ({2'b00, r_min_pwm} - {2'b00, div_rsp.quotient[7:0]})
                               : ({2'b00, r_min_pwm} + {2'b00, div_rsp.quotient[7:0]});

    // Saturate the read quotient toward the signed 32-bit range
    always_comb begin
        if (r_dz_neg) begin
            sat_q = (div_rsp.quotient > SPD_NEG_MAX) ? SPD_NEG_MAX : div_rsp.quotient;
        end else begin
            sat_q = (div_rsp.quotient > SPD_POS_MAX) ? SPD_POS_MAX : div_rsp.quotient;
        end
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (r_state)
            S_IDLE: begin
                // whole rpm by reciprocal of one hundred
                mul_a = {8'b0, cmd_mag};
                mul_b = CENTI_RECIP;
            end
            S_SPD_MUL: begin
                mul_a = {16'b0, r_rpm};
                mul_b = {24'b0, span_mag};
            end
            S_RD_M1: begin
                mul_a = r_dz_mag;
                mul_b = CRPM_SCALE;
            end
            S_RD_M2: begin
                mul_a = {16'b0, ppr_eff};
                mul_b = r_dt;
            end
            S_RD_GO: begin
                mul_a = r_dz_mag;
                mul_b = {16'b0, r_um};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // Hold the product
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_full[MUL_W-1:0];
        end
    end

    // Divider request select
    always_comb begin
        div_req = '0;
        case (r_state)
            S_SPD_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {r_prod[SCL_W-1:0], (DIV_W-SCL_W)'(0)};
                div_req.divisor  = {32'b0, r_max_rpm};
                div_req.count    = SCL_STEPS;
            end
            S_RD_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_dividend;
                div_req.divisor  = r_prod[DEN_W-1:0];
                div_req.count    = READ_STEPS;
            end
            default: begin
                div_req = '0;
            end
        endcase
    end

    dcme_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_rpm <= 16'd300;
            r_min_pwm <= 8'd0;
            r_max_pwm <= 8'd255;
            r_ppr     <= 16'd360;
            r_um      <= 16'd10;
            r_window  <= 16'd50;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_RPM: r_max_rpm <= i_cfg_data;
                CFG_MIN_PWM: r_min_pwm <= i_cfg_data[7:0];
                CFG_MAX_PWM: r_max_pwm <= i_cfg_data[7:0];
                CFG_PPR:     r_ppr     <= i_cfg_data;
                CFG_UM:      r_um      <= i_cfg_data;
                CFG_WINDOW:  r_window  <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // Sequencer and axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= '0;
            r_last_tick <= '0;
            r_last_ms   <= '0;
            r_speed     <= '0;
            r_pos       <= '0;
            r_duty      <= '0;
            r_dir       <= DIR_OFF;
            r_out_valid <= 1'b0;
        end else begin
            // raise a result as the item posts, drop it once taken
            if (r_state == S_POST && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        case (i_opcode)
                            OP_EDGE: begin
                                r_tick  <= (i_enc_a == i_enc_b) ? r_tick + 32'd1
                                                                : r_tick - 32'd1;
                                r_state <= S_POST;
                            end
                            OP_SPEED: begin
                                if (i_speed_cmd == '0) begin
                                    r_duty  <= '0;
                                    r_dir   <= DIR_OFF;
                                    r_state <= S_POST;
                                end else begin
                                    r_state <= S_SPD_RPM;
                                end
                            end
                            OP_STOP: begin
                                r_duty      <= '0;
                                r_dir       <= DIR_OFF;
                                r_tick      <= '0;
                                r_last_tick <= '0;
                                r_speed     <= '0;
                                r_pos       <= '0;
                                r_state     <= S_POST;
                            end
                            OP_READ: begin
                                if (dt_now > {16'b0, r_window}) begin
                                    r_state <= S_RD_M1;
                                end else begin
                                    r_state <= S_POST;
                                end
                            end
                            default: r_state <= S_POST;
                        endcase
                    end
                end
                S_SPD_RPM: begin
                    // whole rpm is in the product: take full duty when max rpm is zero
                    if (r_max_rpm == 16'd0) begin
                        r_duty  <= sat_duty({2'b00, r_max_pwm});
                        r_dir   <= r_cmd_neg ? DIR_REV : DIR_FWD;
                        r_state <= S_POST;
                    end else begin
                        r_state <= S_SPD_MUL;
                    end
                end
                S_SPD_MUL: r_state <= S_SPD_GO;
                S_SPD_GO:  r_state <= S_SPD_DIV;
                S_SPD_DIV: begin
                    if (div_rsp.done) begin
                        r_duty  <= sat_duty(duty_sum);
                        r_dir   <= r_cmd_neg ? DIR_REV : DIR_FWD;
                        r_state <= S_POST;
                    end
                end
                S_RD_M1: r_state <= S_RD_M2;
                S_RD_M2: r_state <= S_RD_GO;
                S_RD_GO: r_state <= S_RD_DIV;
                S_RD_DIV: begin
                    // apply the measured speed and travel, advance the window
                    if (div_rsp.done) begin
                        r_speed     <= r_dz_neg ? 32'd0 - sat_q[31:0] : sat_q[31:0];
                        r_pos       <= r_dz_neg ? r_pos - r_prod[47:0] : r_pos + r_prod[47:0];
                        r_last_tick <= r_tick;
                        r_last_ms   <= r_now;
                        r_state     <= S_POST;
                    end
                end
                S_POST: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd_neg <= i_speed_cmd[23];
            r_dz_neg  <= dz[31];
            r_dz_mag  <= dz[31] ? 32'd0 - dz : dz;
            r_dt      <= dt_now;
            r_now     <= i_now_ms;
        end
        if (r_state == S_SPD_RPM) begin
            r_rpm <= (r_prod[CENTI_SHIFT +: CMD_W] > {8'b0, r_max_rpm})
                   ? r_max_rpm : r_prod[CENTI_SHIFT +: 16];
        end
        if (r_state == S_RD_M2) begin
            r_dividend <= r_prod[DIV_W-1:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_POST && out_free) begin
            o_pwm_duty       <= r_duty;
            o_drive_fwd      <= r_dir[0];
            o_drive_rev      <= r_dir[1];
            o_speed_centirpm <= r_speed;
            o_position_um    <= r_pos;
        end
    end

    assign o_out_valid = r_out_valid;

    // Checks
    `AXIS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, o_in_stall)
    `AXIS_ASSERT_NOW(a_div_done_waited, i_clk, i_rst_n, div_rsp.done, div_wait)
    `AXIS_ASSERT_NEXT(a_post_holds, i_clk, i_rst_n, (r_state == S_POST) && r_out_valid && i_out_stall, r_state == S_POST)
    `AXIS_ASSERT_NOW(a_dir_exclusive, i_clk, i_rst_n, 1'b1, !(r_dir[0] && r_dir[1]))

endmodule
